// ===== design/srti_pkg.sv =====
// Shared definitions for the sorted range table insert unit.
// Action and status codes and default sizes. No dependencies.
package srti_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 64;
    localparam int unsigned DEF_TAG_WIDTH   = 32;

    // Action codes carried in the request beat
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // Status codes carried in the response beat
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

endpackage

// ===== design/srti_if.sv =====
// Request and response channel interfaces of the sorted range table unit.
// Depends on nothing but the tag width parameter.
interface srti_req_if #(parameter int unsigned TAG_WIDTH = 32);
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [15:0]          range_first;
    logic [15:0]          range_last;
    logic [TAG_WIDTH-1:0] range_tag;
    logic [5:0]           read_index;

    modport source (output valid, action, range_first, range_last, range_tag, read_index,
                    input ready);
    modport sink   (input valid, action, range_first, range_last, range_tag, read_index,
                    output ready);
endinterface

interface srti_rsp_if #(parameter int unsigned TAG_WIDTH = 32);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [6:0]           entry_count;
    logic                 entry_valid;
    logic [15:0]          entry_first;
    logic [15:0]          entry_last;
    logic [TAG_WIDTH-1:0] entry_tag;

    modport source (output valid, status, entry_count, entry_valid, entry_first, entry_last,
                    entry_tag, input ready);
    modport sink   (input valid, status, entry_count, entry_valid, entry_first, entry_last,
                    entry_tag, output ready);
endinterface

// ===== design/sorted_range_table_insert_unit.sv =====
// Sorted range table insert unit: top level, sequencer and table memory.
// Depends on srti_pkg and the channel interfaces in srti_if.sv.
//
// Usage
//   i_req carries one action per beat: insert a range [range_first,
//   range_last] with a tag, or read the table entry at read_index.
//   o_rsp returns one beat per request: status, entry count after the
//   action and, for a read, the entry (zeroes when the index is not held).
//   The unit takes one request at a time: i_req.ready is high only when
//   it is idle and no response is waiting.
// Sequence
//   A read fetches its entry in S_RDOUT before the response. An insert
//   does a tail check, a binary search (log2 of the count probes, each
//   a read and a check), then moves table entries one at a time, with a
//   read state and a write state for each entry. Opening a gap moves
//   every entry above the insert point; each removed overlapped range
//   moves every entry above it down.
// Reset
//   i_rst_n empties the table (count zero); stored entries are not cleared.
// Stalls
//   The response is held in registers until o_rsp.ready is seen high.
module sorted_range_table_insert_unit
    import srti_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int unsigned TAG_WIDTH   = DEF_TAG_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srti_req_if.sink   i_req,
    srti_rsp_if.source o_rsp
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IW = (CW > 6) ? CW : 6;
    localparam int unsigned EW = 32 + TAG_WIDTH;
    localparam logic [CW:0] DEPTH_W = (CW+1)'(TABLE_DEPTH);

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_RDOUT = 18'h00002,
        S_LAST  = 18'h00004,
        S_SRCH  = 18'h00008,
        S_SCHK  = 18'h00010,
        S_FETCH = 18'h00020,
        S_CLASS = 18'h00040,
        S_SCAN  = 18'h00080,
        S_SCHK2 = 18'h00100,
        S_INS   = 18'h00200,
        S_OPRD  = 18'h00400,
        S_OPWR  = 18'h00800,
        S_FIN   = 18'h01000,
        S_SPLA  = 18'h02000,
        S_SPLB  = 18'h04000,
        S_CLRD  = 18'h08000,
        S_CLWR  = 18'h10000,
        S_OUT   = 18'h20000
    } t_state;

    // Table memory: {first, last, tag}
    logic [EW-1:0] r_mem [TABLE_DEPTH];
    logic [EW-1:0] r_rdata;
    logic [AW-1:0] c_raddr, c_waddr;
    logic [EW-1:0] c_wdata;
    logic          c_we;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi, r_m, n_m, r_i, n_i, r_k, n_k;
    logic          r_gap2, n_gap2, r_split, n_split, r_ev, n_ev;
    logic [15:0]   r_f, n_f, r_l, n_l;
    logic [TAG_WIDTH-1:0] r_t, n_t;
    logic [EW-1:0] r_e, n_e;
    logic [1:0]    r_status, n_status;
    logic [15:0]   r_ef, n_ef, r_el, n_el;
    logic [TAG_WIDTH-1:0] r_et, n_et;

    logic [15:0]   d_first, d_last, e_first, e_last;
    logic [TAG_WIDTH-1:0] e_tag;
    logic [CW-1:0] c_mid;
    logic [IW-1:0] c_idx;
    logic          c_room1, c_room2, c_acc;

    assign d_first = r_rdata[EW-1 -: 16];
    assign d_last  = r_rdata[EW-17 -: 16];
    assign e_first = r_e[EW-1 -: 16];
    assign e_last  = r_e[EW-17 -: 16];
    assign e_tag   = r_e[TAG_WIDTH-1:0];
    assign c_mid   = r_lo + ((r_hi - r_lo + CW'(1)) >> 1);
    assign c_idx   = IW'(i_req.read_index);
    assign c_room1 = ({1'b0, r_count} + (CW+1)'(1)) <= DEPTH_W;
    assign c_room2 = ({1'b0, r_count} + (CW+1)'(2)) <= DEPTH_W;
    assign c_acc   = i_req.valid && i_req.ready;

    // Sequencer
    always_comb begin
        n_state = r_state; n_count = r_count; n_lo = r_lo; n_hi = r_hi; n_m = r_m;
        n_i = r_i; n_k = r_k; n_gap2 = r_gap2; n_split = r_split; n_ev = r_ev;
        n_f = r_f; n_l = r_l; n_t = r_t; n_e = r_e; n_status = r_status;
        n_ef = r_ef; n_el = r_el; n_et = r_et;
        c_raddr = '0; c_waddr = '0; c_wdata = '0; c_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (c_acc) begin
                    n_f = i_req.range_first; n_l = i_req.range_last; n_t = i_req.range_tag;
                    n_status = ST_OK; n_ef = '0; n_el = '0; n_et = '0; n_ev = 1'b0;
                    if (i_req.action == ACT_READ) begin
                        n_ev = c_idx < IW'(r_count);
                        c_raddr = c_idx[AW-1:0];
                        n_state = S_RDOUT;
                    end else if (i_req.range_last < i_req.range_first) begin
                        n_status = ST_ORDER;
                        n_state = S_OUT;
                    end else if (r_count != '0) begin
                        c_raddr = AW'(r_count - CW'(1));
                        n_state = S_LAST;
                    end else begin
                        n_i = '0;
                        n_state = S_INS;
                    end
                end
            end
            S_RDOUT: begin
                if (r_ev) begin
                    n_ef = d_first; n_el = d_last; n_et = r_rdata[TAG_WIDTH-1:0];
                end
                n_state = S_OUT;
            end
            // Tail check: append past the last range
            S_LAST: begin
                if (d_last < r_f) begin
                    if (c_room1) begin
                        c_we = 1'b1; c_waddr = AW'(r_count);
                        c_wdata = {r_f, r_l, r_t};
                        n_count = r_count + CW'(1);
                    end else begin
                        n_status = ST_FULL;
                    end
                    n_state = S_OUT;
                end else begin
                    n_lo = '0; n_hi = r_count - CW'(1);
                    n_state = S_SRCH;
                end
            end
            // Binary search probe
            S_SRCH: begin
                n_m = c_mid;
                c_raddr = AW'(c_mid);
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (r_f >= d_first && r_f <= d_last) begin
                    n_i = r_m; n_state = S_FETCH;
                end else if (r_f < d_first) begin
                    if (r_m <= r_lo) begin
                        n_i = r_m; n_state = S_FETCH;
                    end else begin
                        n_hi = r_m - CW'(1); n_state = S_SRCH;
                    end
                end else begin
                    if (r_m >= r_hi) begin
                        n_i = r_m + CW'(1); n_state = S_FETCH;
                    end else begin
                        n_lo = r_m + CW'(1); n_state = S_SRCH;
                    end
                end
            end
            S_FETCH: begin
                c_raddr = AW'(r_i);
                n_state = S_CLASS;
            end
            // Classify against the entry at the insert point
            S_CLASS: begin
                n_e = r_rdata;
                if (r_i >= r_count || r_l < d_first) begin
                    n_state = S_INS;
                end else if (r_f == d_first && r_l == d_last) begin
                    c_we = 1'b1; c_waddr = AW'(r_i); c_wdata = {r_f, r_l, r_t};
                    n_state = S_OUT;
                end else if (r_f > d_first && r_l < d_last) begin
                    if (c_room2) begin
                        n_k = r_count; n_gap2 = 1'b1; n_split = 1'b1;
                        n_state = S_OPRD;
                    end else begin
                        n_status = ST_FULL; n_state = S_OUT;
                    end
                end else if (r_l < d_last) begin
                    c_we = 1'b1; c_waddr = AW'(r_i);
                    c_wdata = {r_l + 16'd1, d_last, r_rdata[TAG_WIDTH-1:0]};
                    n_state = S_INS;
                end else if (r_f > d_first) begin
                    c_we = 1'b1; c_waddr = AW'(r_i);
                    c_wdata = {d_first, r_f - 16'd1, r_rdata[TAG_WIDTH-1:0]};
                    n_i = r_i + CW'(1);
                    n_state = S_SCAN;
                end else begin
                    n_k = r_i; n_state = S_CLRD;
                end
            end
            // Walk over ranges covered by the new one
            S_SCAN: begin
                c_raddr = AW'(r_i);
                n_state = (r_i < r_count) ? S_SCHK2 : S_INS;
            end
            S_SCHK2: begin
                if (r_l >= d_first) begin
                    if (r_l < d_last) begin
                        c_we = 1'b1; c_waddr = AW'(r_i);
                        c_wdata = {r_l + 16'd1, d_last, r_rdata[TAG_WIDTH-1:0]};
                        n_state = S_INS;
                    end else begin
                        n_k = r_i; n_state = S_CLRD;
                    end
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                if (c_room1) begin
                    n_k = r_count; n_gap2 = 1'b0; n_split = 1'b0;
                    n_state = S_OPRD;
                end else begin
                    n_status = ST_FULL; n_state = S_OUT;
                end
            end
            // Open a gap of one or two slots at the insert point
            S_OPRD: begin
                if (r_k > r_i) begin
                    n_k = r_k - CW'(1);
                    c_raddr = AW'(r_k - CW'(1));
                    n_state = S_OPWR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_OPWR: begin
                c_we = 1'b1; c_wdata = r_rdata;
                c_waddr = AW'(r_k + (r_gap2 ? CW'(2) : CW'(1)));
                n_state = S_OPRD;
            end
            S_FIN: begin
                c_we = 1'b1; c_wdata = {r_f, r_l, r_t};
                if (r_split) begin
                    c_waddr = AW'(r_i + CW'(1));
                    n_state = S_SPLA;
                end else begin
                    c_waddr = AW'(r_i);
                    n_count = r_count + CW'(1);
                    n_state = S_OUT;
                end
            end
            S_SPLA: begin
                c_we = 1'b1; c_waddr = AW'(r_i + CW'(2));
                c_wdata = {r_l + 16'd1, e_last, e_tag};
                n_state = S_SPLB;
            end
            S_SPLB: begin
                c_we = 1'b1; c_waddr = AW'(r_i);
                c_wdata = {e_first, r_f - 16'd1, e_tag};
                n_count = r_count + CW'(2);
                n_state = S_OUT;
            end
            // Remove the entry at r_k, closing the hole
            S_CLRD: begin
                if (r_k + CW'(1) < r_count) begin
                    c_raddr = AW'(r_k + CW'(1));
                    n_state = S_CLWR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_SCAN;
                end
            end
            S_CLWR: begin
                c_we = 1'b1; c_waddr = AW'(r_k); c_wdata = r_rdata;
                n_k = r_k + CW'(1);
                n_state = S_CLRD;
            end
            S_OUT: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (c_we) r_mem[c_waddr] <= c_wdata;
        r_rdata <= r_mem[c_raddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_lo <= n_lo; r_hi <= n_hi; r_m <= n_m; r_i <= n_i; r_k <= n_k;
        r_gap2 <= n_gap2; r_split <= n_split; r_ev <= n_ev;
        r_f <= n_f; r_l <= n_l; r_t <= n_t; r_e <= n_e; r_status <= n_status;
        r_ef <= n_ef; r_el <= n_el; r_et <= n_et;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = (r_state == S_OUT);
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = 7'(r_count);
    assign o_rsp.entry_valid = r_ev;
    assign o_rsp.entry_first = r_ef;
    assign o_rsp.entry_last  = r_el;
    assign o_rsp.entry_tag   = r_et;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} <= DEPTH_W)
        else $error("entry count beyond table depth");
    a_read_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_acc && i_req.action == ACT_READ) |=> $stable(r_count))
        else $error("read action changed the entry count");
    a_read_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_ev) |-> (r_status == ST_OK))
        else $error("read response with non-ok status");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request taken while response pending");
    a_order_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_acc && i_req.action == ACT_INSERT && i_req.range_last < i_req.range_first)
        |=> $stable(r_count))
        else $error("reversed range changed the table");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the sorted range table insert unit: directed and random
// inserts and reads, checked against a behavioural model of the range table.
// Depends on srti_pkg, srti_if.sv and the unit's RTL.
module tb_top;
    import srti_pkg::*;

    localparam int unsigned DEPTH = DEF_TABLE_DEPTH;
    localparam int unsigned TW    = DEF_TAG_WIDTH;
    localparam int          N_RANDOM = 1390;

    typedef struct packed {
        logic [1:0]    status;
        logic [6:0]    entry_count;
        logic          entry_valid;
        logic [15:0]   entry_first;
        logic [15:0]   entry_last;
        logic [TW-1:0] entry_tag;
    } range_reply_t;

    // Behavioural range table and queue of expected replies
    class range_table_sb;
        logic [15:0]   lo_q[DEPTH+2];
        logic [15:0]   hi_q[DEPTH+2];
        logic [TW-1:0] tag_q[DEPTH+2];
        int unsigned   count;
        range_reply_t  pending_q[$];
        int            errors;

        function new();
            count = 0;
            errors = 0;
        endfunction

        function void move_slot(int unsigned dst, int unsigned src);
            lo_q[dst] = lo_q[src];
            hi_q[dst] = hi_q[src];
            tag_q[dst] = tag_q[src];
        endfunction

        function void shift_up(int unsigned pos, int unsigned gap);
            int unsigned k;
            k = count;
            while (k > pos) begin
                k--;
                move_slot(k + gap, k);
            end
        endfunction

        function void remove_at(int unsigned pos);
            int unsigned k;
            for (k = pos; k + 1 < count; k++) move_slot(k, k + 1);
            if (count > 0) count--;
        endfunction

        function void place(int unsigned pos, logic [15:0] f, logic [15:0] l,
                            logic [TW-1:0] t);
            lo_q[pos] = f;
            hi_q[pos] = l;
            tag_q[pos] = t;
        endfunction

        // Binary search for the slot that holds or follows the key
        function int unsigned find_slot(logic [15:0] key);
            int unsigned lo, hi, m;
            if (count == 0) return 0;
            lo = 0;
            hi = count - 1;
            forever begin
                m = lo + (hi - lo + 1) / 2;
                if (key >= lo_q[m] && key <= hi_q[m]) return m;
                if (key < lo_q[m]) begin
                    if (m <= lo) return m;
                    hi = m - 1;
                end else begin
                    if (m >= hi) begin
                        if (m < count) m++;
                        return m;
                    end
                    lo = m + 1;
                end
            end
        endfunction

        function logic [1:0] insert_range(logic [15:0] f, logic [15:0] l,
                                          logic [TW-1:0] t);
            int unsigned i;
            if (l < f) return ST_ORDER;
            if (count > 0 && hi_q[count-1] < f) begin
                if (count + 1 > DEPTH) return ST_FULL;
                place(count, f, l, t);
                count++;
                return ST_OK;
            end
            i = find_slot(f);
            if (i >= count || l < lo_q[i]) begin
                if (count + 1 > DEPTH) return ST_FULL;
                shift_up(i, 1);
                place(i, f, l, t);
                count++;
                return ST_OK;
            end
            if (f == lo_q[i] && l == hi_q[i]) begin
                place(i, f, l, t);
                return ST_OK;
            end
            // new range strictly inside an existing one: split in three
            if (f > lo_q[i] && l < hi_q[i]) begin
                if (count + 2 > DEPTH) return ST_FULL;
                shift_up(i, 2);
                place(i + 1, f, l, t);
                move_slot(i + 2, i);
                hi_q[i] = f - 16'd1;
                lo_q[i + 2] = l + 16'd1;
                count += 2;
                return ST_OK;
            end
            // overlap: trim or drop neighbours; these edits stand even if full
            if (f <= lo_q[i] && l < hi_q[i]) begin
                lo_q[i] = l + 16'd1;
            end else begin
                if (f > lo_q[i]) begin
                    hi_q[i] = f - 16'd1;
                    i++;
                end else begin
                    remove_at(i);
                end
                while (i < count && l >= lo_q[i]) begin
                    if (l < hi_q[i]) begin
                        lo_q[i] = l + 16'd1;
                        break;
                    end
                    remove_at(i);
                end
            end
            if (count + 1 > DEPTH) return ST_FULL;
            shift_up(i, 1);
            place(i, f, l, t);
            count++;
            return ST_OK;
        endfunction

        function void note_request(logic act, logic [15:0] f, logic [15:0] l,
                                   logic [TW-1:0] t, logic [5:0] idx);
            range_reply_t r;
            r = '0;
            if (act == ACT_INSERT) begin
                r.status = insert_range(f, l, t);
            end else if (idx < count) begin
                r.entry_valid = 1'b1;
                r.entry_first = lo_q[idx];
                r.entry_last = hi_q[idx];
                r.entry_tag = tag_q[idx];
            end
            r.entry_count = count[6:0];
            pending_q.push_back(r);
        endfunction

        function void check_reply(range_reply_t got);
            range_reply_t want;
            if (pending_q.size() == 0) begin
                $error("reply beat with nothing expected");
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status) begin
                $error("status exp %0d got %0d", want.status, got.status);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count exp %0d got %0d", want.entry_count, got.entry_count);
                errors++;
            end
            if (got.entry_valid !== want.entry_valid) begin
                $error("entry_valid exp %0d got %0d", want.entry_valid, got.entry_valid);
                errors++;
            end
            if (got.entry_first !== want.entry_first) begin
                $error("entry_first exp %h got %h", want.entry_first, got.entry_first);
                errors++;
            end
            if (got.entry_last !== want.entry_last) begin
                $error("entry_last exp %h got %h", want.entry_last, got.entry_last);
                errors++;
            end
            if (got.entry_tag !== want.entry_tag) begin
                $error("entry_tag exp %h got %h", want.entry_tag, got.entry_tag);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    range_table_sb table_sb;
    int unsigned   stall_phase;

    srti_req_if #(.TAG_WIDTH(TW)) req_if ();
    srti_rsp_if #(.TAG_WIDTH(TW)) rsp_if ();

    sorted_range_table_insert_unit #(.TABLE_DEPTH(DEPTH), .TAG_WIDTH(TW)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.action = ACT_INSERT;
        req_if.range_first = '0;
        req_if.range_last = '0;
        req_if.range_tag = '0;
        req_if.read_index = '0;
        rsp_if.ready = 1'b0;
        table_sb = new();
        stall_phase = 0;
    end

    // Reply side: stall on a rotating pattern, check each accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            table_sb.check_reply({rsp_if.status, rsp_if.entry_count, rsp_if.entry_valid,
                                  rsp_if.entry_first, rsp_if.entry_last, rsp_if.entry_tag});
        end
        stall_phase <= stall_phase + 1;
        if (stall_phase[9:8] == 2'd0)
            rsp_if.ready <= 1'b1;
        else if (stall_phase[9:8] == 2'd1)
            rsp_if.ready <= ($urandom_range(0, 3) != 0);
        else
            rsp_if.ready <= ($urandom_range(0, 1) == 0);
    end

    int burst_left;

    // Present one request and hold it until accepted; gaps between bursts
    task automatic send_request(logic act, logic [15:0] f, logic [15:0] l,
                                logic [TW-1:0] t, logic [5:0] idx);
        int gap;
        if (burst_left <= 0) begin
            burst_left = int'($urandom_range(1, 12));
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 40));
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.action <= act;
        req_if.range_first <= f;
        req_if.range_last <= l;
        req_if.range_tag <= t;
        req_if.read_index <= idx;
        do @(posedge i_clk); while (!req_if.ready);
        table_sb.note_request(act, f, l, t, idx);
    endtask

    task automatic send_random();
        logic [15:0] f, l, span;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            send_request(ACT_READ, '0, '0, TW'($urandom), 6'($urandom_range(0, 63)));
        end else begin
            // mostly narrow ranges in a small window so that overlaps are common
            if (sel < 85) begin
                f = 16'($urandom_range(0, 1023));
                span = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
                                                       : $urandom_range(0, 20));
                l = (f + span > 16'hFFFF) ? 16'hFFFF : f + span;
            end else if (sel < 95) begin
                f = 16'($urandom);
                l = 16'($urandom);
                if (l < f && $urandom_range(0, 2) != 0) {f, l} = {l, f};
            end else begin
                f = 16'($urandom_range(0, 1023));
                l = f - 16'($urandom_range(1, 5));
            end
            send_request(ACT_INSERT, f, l, TW'($urandom), 6'($urandom));
        end
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        burst_left = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: empty reads, append, front insert, equal replace, split,
        // overlap trims, reversed range, extremes of every field
        send_request(ACT_READ, '0, '0, '0, 6'd0);
        send_request(ACT_READ, 16'hFFFF, 16'hFFFF, '1, 6'd63);
        send_request(ACT_INSERT, 16'd100, 16'd199, 32'h1111_1111, '0);
        send_request(ACT_INSERT, 16'd300, 16'd399, 32'h2222_2222, '1);
        send_request(ACT_INSERT, 16'd0, 16'd9, '0, '0);
        send_request(ACT_INSERT, 16'd100, 16'd199, '1, '0);
        send_request(ACT_INSERT, 16'd120, 16'd130, 32'hA5A5_5A5A, '0);
        send_request(ACT_INSERT, 16'd90, 16'd110, 32'h3333_3333, '0);
        send_request(ACT_INSERT, 16'd125, 16'd350, 32'h4444_4444, '0);
        send_request(ACT_INSERT, 16'd5, 16'd4, 32'h5555_5555, '0);
        send_request(ACT_INSERT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, '0);
        send_request(ACT_INSERT, 16'd0, 16'hFFFF, 32'h6666_6666, '0);
        for (n = 0; n < 4; n++) send_request(ACT_READ, '0, '0, '0, n[5:0]);
        send_request(ACT_INSERT, 16'd200, 16'd200, 32'h7777_7777, '0);
        send_request(ACT_READ, '0, '0, '0, 6'd1);
        send_request(ACT_READ, '0, '0, '0, 6'd2);
        // Random phase
        for (n = 0; n < N_RANDOM; n++) begin
            send_random();
            // fill the table now and then to reach the full status
            if (n % 400 == 200) begin
                int k;
                for (k = 0; k < 70; k++)
                    send_request(ACT_INSERT, 16'(40000 + k * 4), 16'(40001 + k * 4),
                                 TW'($urandom), '0);
                for (k = 0; k < 8; k++)
                    send_request(ACT_INSERT, 16'(40000 + k * 16), 16'(40000 + k * 16 + 5),
                                 TW'($urandom), '0);
                send_request(ACT_READ, '0, '0, '0, 6'd63);
                send_request(ACT_INSERT, 16'd0, 16'hFFFF, TW'($urandom), '0);
            end
        end
        req_if.valid <= 1'b0;
        while (table_sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (table_sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #150000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sorted_range_table_insert_unit.f =====
design/srti_pkg.sv
design/srti_if.sv
design/sorted_range_table_insert_unit.sv
tb/sv/tb_top.sv
